/* hw/rtl/air_cp_enthalpy_interpolator_defines.svh */
// assertion macros shared by the air cp / enthalpy interpolator rtl
`ifndef AIR_CP_ENTHALPY_INTERPOLATOR_DEFINES_SVH
`define AIR_CP_ENTHALPY_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define ACEI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define ACEI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/acei_pkg.sv */
// package: widths, codes, constants and rom tables of the air cp / enthalpy interpolator
package acei_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int ROM_ENTRIES   = 32;
  localparam int USED_ENTRIES  = (TABLE_ENTRIES > ROM_ENTRIES) ? ROM_ENTRIES :
                                 ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int LAST_ENTRY    = USED_ENTRIES - 1;
  localparam int IDX_W         = $clog2(ROM_ENTRIES);

  // port field widths
  localparam int T_W        = 16;
  localparam int CP_W       = 19;
  localparam int H_W        = 28;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // internal widths
  localparam int CP_INT_W   = 11;
  localparam int CP_FRAC_W  = 8;
  localparam int H_ROM_W    = 24;
  localparam int FRAC_BITS  = 20;
  localparam int PROD_W     = 2 * T_W;
  localparam int IDXF_W     = PROD_W - FRAC_BITS;
  localparam int LIN_W      = T_W + CP_INT_W;
  localparam int X_W        = 20;
  localparam int QUAD_W     = 36;

  // region codes
  typedef logic [REGION_W-1:0] region_t;
  localparam region_t REGION_BELOW = 2'd0;
  localparam region_t REGION_TABLE = 2'd1;
  localparam region_t REGION_ABOVE = 2'd2;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TABLE_START  = 2'd0;
  localparam cfg_idx_t CFG_INVERSE_STEP = 2'd1;
  localparam cfg_idx_t CFG_UPPER        = 2'd2;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] TABLE_START_RESET  = 16'd4400;
  localparam logic [CFG_DATA_W-1:0] INVERSE_STEP_RESET = 16'd2621;
  localparam logic [CFG_DATA_W-1:0] UPPER_RESET        = 16'd16800;

  // cp table in whole J/(kg K); the Q.8 value is this shifted left by eight
  typedef logic [CP_INT_W-1:0] cp_int_t;
  localparam cp_int_t CP_ROM [ROM_ENTRIES] = '{
    11'd1005, 11'd1006, 11'd1007, 11'd1009, 11'd1012, 11'd1015, 11'd1018, 11'd1022,
    11'd1024, 11'd1031, 11'd1036, 11'd1041, 11'd1046, 11'd1051, 11'd1057, 11'd1063,
    11'd1069, 11'd1075, 11'd1080, 11'd1086, 11'd1092, 11'd1098, 11'd1104, 11'd1109,
    11'd1115, 11'd1120, 11'd1126, 11'd1131, 11'd1136, 11'd1141, 11'd1146, 11'd1150
  };

  // enthalpy table in Q.4 J/kg
  typedef logic [H_ROM_W-1:0] h_rom_t;
  localparam h_rom_t H_ROM [ROM_ENTRIES] = '{
    24'd0,        24'd402200,   24'd804800,   24'd1208000,  24'd1612200,  24'd2017600,
    24'd2424200,  24'd2832200,  24'd3241400,  24'd3652400,  24'd4065800,  24'd4481200,
    24'd4898600,  24'd5318000,  24'd5739600,  24'd6163600,  24'd6590000,  24'd7018800,
    24'd7449800,  24'd7883000,  24'd8318600,  24'd8756600,  24'd9197000,  24'd9639600,
    24'd10084400, 24'd10531400, 24'd10980600, 24'd11432000, 24'd11885400, 24'd12340800,
    24'd12798200, 24'd13257400
  };

  localparam cp_int_t CP_FIRST = CP_ROM[0];
  localparam cp_int_t CP_LAST  = CP_ROM[LAST_ENTRY];
  localparam h_rom_t  H_LAST   = H_ROM[LAST_ENTRY];

  // cp slope above the table: round(d * 11 / 5000)
  localparam int CP_SLOPE_MUL    = 11;
  localparam int CP_SLOPE_ROUND  = 2500;
  localparam int CP_RECIP_W      = 20;
  localparam int CP_RECIP_SHIFT  = 32;
  localparam logic [CP_RECIP_W-1:0] CP_RECIP = 20'd858994;  // ceil(2^32 / 5000)
  localparam int QCP_W           = X_W + CP_RECIP_W - CP_RECIP_SHIFT;

  // quadratic enthalpy term: floor((11 * d^2 + 1280000) / 2560000)
  localparam int H_QUAD_MUL      = 11;
  localparam int H_QUAD_ROUND    = 1280000;
  localparam int H_PRESHIFT      = 12;                      // 2560000 = 2^12 * 625
  localparam int YQ_W            = QUAD_W - H_PRESHIFT;
  localparam int H_RECIP_W       = 25;
  localparam int H_RECIP_SHIFT   = 34;
  localparam logic [H_RECIP_W-1:0] H_RECIP = 25'd27487791;  // ceil(2^34 / 625)
  localparam int QH_W            = YQ_W + H_RECIP_W - H_RECIP_SHIFT;

  // enthalpy saturation below the table
  localparam int H_NEG_LIMIT = 8388608;
  localparam logic signed [H_W-1:0] H_MIN = H_W'(-H_NEG_LIMIT);

endpackage

/* hw/rtl/acei_ifs.sv */
// channel interfaces of the air cp / enthalpy interpolator

// temperature transaction channel
interface acei_in_if;
  logic                      valid;
  logic                      ready;
  logic [acei_pkg::T_W-1:0]  temperature_q4;
  modport source (output valid, output temperature_q4, input ready);
  modport sink   (input valid, input temperature_q4, output ready);
endinterface

// result transaction channel
interface acei_out_if;
  logic                            valid;
  logic                            ready;
  logic [acei_pkg::CP_W-1:0]       heat_capacity_q8;
  logic signed [acei_pkg::H_W-1:0] enthalpy_q4;
  logic [acei_pkg::REGION_W-1:0]   region;
  modport source (output valid, output heat_capacity_q8, output enthalpy_q4,
                  output region, input ready);
  modport sink   (input valid, input heat_capacity_q8, input enthalpy_q4,
                  input region, output ready);
endinterface

// configuration write channel
interface acei_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [acei_pkg::CFG_IDX_W-1:0]    index;
  logic [acei_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/air_cp_enthalpy_interpolator.sv */
// top level: five-stage pipelined cp / enthalpy table interpolator
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      temperature_q4 (Q12.4 K)
//   out_ch   out  valid / ready      heat_capacity_q8, enthalpy_q4, region
//   cfg_ch   in   valid / ready (=1) index, data
//
// one transaction per cycle sustained while the output is not stalled; the stages are
// region select, main multiply, table read / reciprocal multiply, interpolation
// multiply and final add. rst_n is synchronous, clears the valid bits and reloads the
// configuration registers. a stalled output freezes every stage together, so in_ch.ready
// follows out_ch.ready whenever the output register is full.

`include "air_cp_enthalpy_interpolator_defines.svh"

module air_cp_enthalpy_interpolator (
  input  logic         clk,
  input  logic         rst_n,
  acei_in_if.sink      in_ch,
  acei_out_if.source   out_ch,
  acei_cfg_if.sink     cfg_ch
);

  // configuration registers
  logic [acei_pkg::CFG_DATA_W-1:0] start_r;
  logic [acei_pkg::CFG_DATA_W-1:0] inv_step_r;
  logic [acei_pkg::CFG_DATA_W-1:0] upper_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= acei_pkg::TABLE_START_RESET;
      inv_step_r <= acei_pkg::INVERSE_STEP_RESET;
      upper_r    <= acei_pkg::UPPER_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        acei_pkg::CFG_TABLE_START:  start_r    <= cfg_ch.data;
        acei_pkg::CFG_INVERSE_STEP: inv_step_r <= cfg_ch.data;
        acei_pkg::CFG_UPPER:        upper_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic pipe_en;
  logic out_valid_r;
  assign pipe_en     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = pipe_en;

  // valid bits
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // stage 1: region select and temperature offset
  acei_pkg::region_t                s1_region_r, s1_region_nxt;
  logic [acei_pkg::T_W-1:0]         s1_delta_r, s1_delta_nxt;

  always_comb begin
    if (in_ch.temperature_q4 < start_r) begin
      s1_region_nxt = acei_pkg::REGION_BELOW;
      s1_delta_nxt  = start_r - in_ch.temperature_q4;
    end else if (in_ch.temperature_q4 >= upper_r) begin
      s1_region_nxt = acei_pkg::REGION_ABOVE;
      s1_delta_nxt  = in_ch.temperature_q4 - upper_r;
    end else begin
      s1_region_nxt = acei_pkg::REGION_TABLE;
      s1_delta_nxt  = in_ch.temperature_q4 - start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_region_r <= s1_region_nxt;
      s1_delta_r  <= s1_delta_nxt;
    end
  end

  // stage 2: grid position (delta * inverse step) or delta squared, plus linear terms
  acei_pkg::region_t                s2_region_r;
  logic [acei_pkg::PROD_W-1:0]      s2_prod_r, s2_prod_nxt;
  logic [acei_pkg::LIN_W-1:0]       s2_lin_r, s2_lin_nxt;
  logic [acei_pkg::X_W-1:0]         s2_x_r, s2_x_nxt;
  logic [acei_pkg::T_W-1:0]         s2_opb;
  acei_pkg::cp_int_t                s2_lin_coef;

  always_comb begin
    s2_opb      = (s1_region_r == acei_pkg::REGION_TABLE) ? inv_step_r : s1_delta_r;
    s2_lin_coef = (s1_region_r == acei_pkg::REGION_BELOW) ? acei_pkg::CP_FIRST
                                                          : acei_pkg::CP_LAST;
    s2_prod_nxt = acei_pkg::PROD_W'(s1_delta_r) * acei_pkg::PROD_W'(s2_opb);
    s2_lin_nxt  = acei_pkg::LIN_W'(s1_delta_r) * acei_pkg::LIN_W'(s2_lin_coef);
    s2_x_nxt    = acei_pkg::X_W'(s1_delta_r) * acei_pkg::X_W'(acei_pkg::CP_SLOPE_MUL)
                + acei_pkg::X_W'(acei_pkg::CP_SLOPE_ROUND);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_region_r <= s1_region_r;
      s2_prod_r   <= s2_prod_nxt;
      s2_lin_r    <= s2_lin_nxt;
      s2_x_r      <= s2_x_nxt;
    end
  end

  // stage 3: table read, cp slope quotient, enthalpy quadratic numerator
  acei_pkg::region_t                 s3_region_r;
  logic [acei_pkg::FRAC_BITS-1:0]    s3_frac_r;
  acei_pkg::cp_int_t                 s3_cp0_r, s3_cp0_nxt;
  acei_pkg::cp_int_t                 s3_cpd_r, s3_cpd_nxt;
  acei_pkg::h_rom_t                  s3_h0_r, s3_h0_nxt;
  acei_pkg::h_rom_t                  s3_hd_r, s3_hd_nxt;
  logic [acei_pkg::QCP_W-1:0]        s3_qcp_r;
  logic [acei_pkg::YQ_W-1:0]         s3_yq_r;
  logic [acei_pkg::LIN_W-1:0]        s3_lin_r;
  logic [acei_pkg::IDXF_W-1:0]       s3_idx;
  logic [acei_pkg::IDX_W-1:0]        s3_i0, s3_i1;
  logic                              s3_past;
  logic [acei_pkg::X_W+acei_pkg::CP_RECIP_W-1:0] s3_cpq_prod;
  logic [acei_pkg::QUAD_W-1:0]       s3_quad;

  always_comb begin
    s3_idx  = s2_prod_r[acei_pkg::PROD_W-1:acei_pkg::FRAC_BITS];
    s3_past = s3_idx >= acei_pkg::IDXF_W'(acei_pkg::LAST_ENTRY);
    s3_i0   = s3_idx[acei_pkg::IDX_W-1:0];
    s3_i1   = s3_i0 + acei_pkg::IDX_W'(1);
    // past the usable grid: hold the last entry with no slope
    if (s3_past) begin
      s3_cp0_nxt = acei_pkg::CP_LAST;
      s3_cpd_nxt = '0;
      s3_h0_nxt  = acei_pkg::H_LAST;
      s3_hd_nxt  = '0;
    end else begin
      s3_cp0_nxt = acei_pkg::CP_ROM[s3_i0];
      s3_cpd_nxt = acei_pkg::CP_ROM[s3_i1] - acei_pkg::CP_ROM[s3_i0];
      s3_h0_nxt  = acei_pkg::H_ROM[s3_i0];
      s3_hd_nxt  = acei_pkg::H_ROM[s3_i1] - acei_pkg::H_ROM[s3_i0];
    end
    s3_cpq_prod = (acei_pkg::X_W + acei_pkg::CP_RECIP_W)'(s2_x_r)
                * (acei_pkg::X_W + acei_pkg::CP_RECIP_W)'(acei_pkg::CP_RECIP);
    s3_quad     = acei_pkg::QUAD_W'(s2_prod_r) * acei_pkg::QUAD_W'(acei_pkg::H_QUAD_MUL)
                + acei_pkg::QUAD_W'(acei_pkg::H_QUAD_ROUND);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_region_r <= s2_region_r;
      s3_frac_r   <= s2_prod_r[acei_pkg::FRAC_BITS-1:0];
      s3_cp0_r    <= s3_cp0_nxt;
      s3_cpd_r    <= s3_cpd_nxt;
      s3_h0_r     <= s3_h0_nxt;
      s3_hd_r     <= s3_hd_nxt;
      s3_qcp_r    <= s3_cpq_prod[acei_pkg::X_W+acei_pkg::CP_RECIP_W-1:acei_pkg::CP_RECIP_SHIFT];
      s3_yq_r     <= s3_quad[acei_pkg::QUAD_W-1:acei_pkg::H_PRESHIFT];
      s3_lin_r    <= s2_lin_r;
    end
  end

  // stage 4: interpolation products with half-up rounding, enthalpy quadratic quotient
  localparam int CP_PROD_W  = acei_pkg::FRAC_BITS + acei_pkg::CP_INT_W;
  localparam int CP_SHIFT   = acei_pkg::FRAC_BITS - acei_pkg::CP_FRAC_W;
  localparam int H_PROD_W   = acei_pkg::FRAC_BITS + acei_pkg::H_ROM_W;
  localparam int QH_PROD_W  = acei_pkg::YQ_W + acei_pkg::H_RECIP_W;

  acei_pkg::region_t                 s4_region_r;
  acei_pkg::cp_int_t                 s4_cp0_r;
  acei_pkg::h_rom_t                  s4_h0_r;
  logic [acei_pkg::LIN_W-1:0]        s4_lin_r;
  logic [acei_pkg::CP_W-1:0]         s4_cp_inc_r, s4_cp_inc_nxt;
  acei_pkg::h_rom_t                  s4_h_inc_r, s4_h_inc_nxt;
  logic [CP_PROD_W:0]                s4_cp_sum;
  logic [H_PROD_W:0]                 s4_h_sum;
  logic [QH_PROD_W-1:0]              s4_qh_prod;

  always_comb begin
    s4_cp_sum  = (CP_PROD_W + 1)'(s3_frac_r) * (CP_PROD_W + 1)'(s3_cpd_r)
               + ((CP_PROD_W + 1)'(1) << (CP_SHIFT - 1));
    s4_h_sum   = (H_PROD_W + 1)'(s3_frac_r) * (H_PROD_W + 1)'(s3_hd_r)
               + ((H_PROD_W + 1)'(1) << (acei_pkg::FRAC_BITS - 1));
    s4_qh_prod = QH_PROD_W'(s3_yq_r) * QH_PROD_W'(acei_pkg::H_RECIP);
    if (s3_region_r == acei_pkg::REGION_TABLE) begin
      s4_cp_inc_nxt = s4_cp_sum[CP_SHIFT+acei_pkg::CP_W-1:CP_SHIFT];
      s4_h_inc_nxt  = s4_h_sum[acei_pkg::FRAC_BITS+acei_pkg::H_ROM_W-1:acei_pkg::FRAC_BITS];
    end else begin
      s4_cp_inc_nxt = acei_pkg::CP_W'(s3_qcp_r);
      s4_h_inc_nxt  = acei_pkg::H_ROM_W'(s4_qh_prod[QH_PROD_W-1:acei_pkg::H_RECIP_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_region_r <= s3_region_r;
      s4_cp0_r    <= s3_cp0_r;
      s4_h0_r     <= s3_h0_r;
      s4_lin_r    <= s3_lin_r;
      s4_cp_inc_r <= s4_cp_inc_nxt;
      s4_h_inc_r  <= s4_h_inc_nxt;
    end
  end

  // stage 5: final sums per region into the output register
  logic [acei_pkg::CP_W-1:0]         out_cp_r, out_cp_nxt;
  logic signed [acei_pkg::H_W-1:0]   out_h_r, out_h_nxt;
  acei_pkg::region_t                 out_region_r;

  always_comb begin
    unique case (s4_region_r)
      acei_pkg::REGION_BELOW: begin
        out_cp_nxt = {acei_pkg::CP_FIRST, {acei_pkg::CP_FRAC_W{1'b0}}};
        if (s4_lin_r > acei_pkg::LIN_W'(acei_pkg::H_NEG_LIMIT)) begin
          out_h_nxt = acei_pkg::H_MIN;
        end else begin
          out_h_nxt = -$signed(acei_pkg::H_W'(s4_lin_r));
        end
      end
      acei_pkg::REGION_TABLE: begin
        out_cp_nxt = {s4_cp0_r, {acei_pkg::CP_FRAC_W{1'b0}}} + s4_cp_inc_r;
        out_h_nxt  = $signed(acei_pkg::H_W'(s4_h0_r) + acei_pkg::H_W'(s4_h_inc_r));
      end
      acei_pkg::REGION_ABOVE: begin
        out_cp_nxt = {acei_pkg::CP_LAST, {acei_pkg::CP_FRAC_W{1'b0}}} + s4_cp_inc_r;
        out_h_nxt  = $signed(acei_pkg::H_W'(acei_pkg::H_LAST) + acei_pkg::H_W'(s4_lin_r)
                             + acei_pkg::H_W'(s4_h_inc_r));
      end
      default: begin
        out_cp_nxt = '0;
        out_h_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_cp_r     <= out_cp_nxt;
      out_h_r      <= out_h_nxt;
      out_region_r <= s4_region_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.heat_capacity_q8 = out_cp_r;
  assign out_ch.enthalpy_q4      = out_h_r;
  assign out_ch.region           = out_region_r;

  // checks
  `ACEI_ASSERT_NXT(a_accept_fills_s1, clk, rst_n,
                   in_ch.valid && in_ch.ready, s1_valid_r,
                   "accepted transaction missing from stage one")
  `ACEI_ASSERT_NXT(a_stall_freezes_s4, clk, rst_n, !pipe_en,
                   $stable(s4_valid_r) && $stable(s4_cp_inc_r) && $stable(s4_region_r),
                   "stage four moved during a stall")
  `ACEI_ASSERT_IMP(a_below_not_positive, clk, rst_n,
                   out_valid_r && (out_region_r == acei_pkg::REGION_BELOW),
                   out_h_r <= $signed(acei_pkg::H_W'(0)),
                   "positive enthalpy below the table")
  `ACEI_ASSERT_IMP(a_above_cp_floor, clk, rst_n,
                   out_valid_r && (out_region_r == acei_pkg::REGION_ABOVE),
                   out_cp_r >= {acei_pkg::CP_LAST, {acei_pkg::CP_FRAC_W{1'b0}}},
                   "cp under last entry above the table")

endmodule
